// ===== rtl/plp_pkg.sv =====
// shared types and constants for the prefixed integer literal parser
// no dependencies; used by plp_accum, plp_core and the top level
package plp_pkg;

	localparam int ACC_W = 63;
	localparam int WIDE_W = ACC_W + 4;
	localparam logic [63:0] SAT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_HEX = 2'd1;
	localparam logic [1:0] RX_OCT = 2'd2;
	localparam logic [1:0] RX_BIN = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_D     = 8'h64;

	typedef struct packed {
		logic ok;
		logic ovf;
	} plp_digit_t;

	typedef struct packed {
		logic       emit;
		logic       invalid;
		logic [1:0] radix;
	} plp_ctl_t;

endpackage

// ===== rtl/prefixed_integer_literal_parser_top.sv =====
// an accepted item is held in the input register, and its result is then captured
//   in the output register
// throughput: one character item per cycle; a stalled result holds the parse step,
//   and in_stall follows out_stall in the same cycle once both registers are full
// reset (arst_n low): both registers empty, parser idle with cleared state
module prefixed_integer_literal_parser_top #(
	parameter int COUNT_BITS  = 16,
	parameter int RESULT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             ch,
	input  logic                   begin_req,
	input  logic                   end_of_text,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [RESULT_BITS-1:0] value,
	output logic                   status,
	output logic [1:0]             radix_code,
	output logic [COUNT_BITS-1:0]  blanks_skipped,
	output logic [COUNT_BITS-1:0]  literal_chars
);

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   begin_s1;
	logic                   eot_s1;
	logic                   go;
	logic                   in_fire;
	logic                   out_fire;
	plp_pkg::plp_ctl_t      ctl;
	logic [RESULT_BITS-1:0] res_value;
	logic [COUNT_BITS-1:0]  res_blanks;
	logic [COUNT_BITS-1:0]  res_chars;
	logic                   out_valid_q;
	logic [RESULT_BITS-1:0] value_q;
	logic                   status_q;
	logic [1:0]             radix_q;
	logic [COUNT_BITS-1:0]  blanks_q;
	logic [COUNT_BITS-1:0]  chars_q;

	assign out_fire = out_valid_q && !out_stall;
	// the held item is processed once the output register has room
	assign go       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1    <= ch;
			begin_s1 <= begin_req;
			eot_s1   <= end_of_text;
		end
	end

	plp_core #(
		.COUNT_BITS  (COUNT_BITS),
		.RESULT_BITS (RESULT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.ch          (ch_s1),
		.begin_req   (begin_s1),
		.end_of_text (eot_s1),
		.ctl         (ctl),
		.res_value   (res_value),
		.res_blanks  (res_blanks),
		.res_chars   (res_chars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.emit) begin
			value_q  <= res_value;
			status_q <= ctl.invalid;
			radix_q  <= ctl.radix;
			blanks_q <= res_blanks;
			chars_q  <= res_chars;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign status         = status_q;
	assign radix_code     = radix_q;
	assign blanks_skipped = blanks_q;
	assign literal_chars  = chars_q;

endmodule

// ===== rtl/plp_accum.sv =====
// digit decode and shift-add accumulate with overflow check against 2^63-1
// depends on plp_pkg
module plp_accum (
	input  logic [7:0]                 ch,
	input  logic [1:0]                 radix,
	input  logic [plp_pkg::ACC_W-1:0]  acc,
	output logic [3:0]                 digit,
	output plp_pkg::plp_digit_t        info,
	output logic [plp_pkg::ACC_W-1:0]  acc_next
);

	logic                        is_char;
	logic                        radix_ok;
	logic [plp_pkg::WIDE_W-1:0]  prod;
	logic [plp_pkg::WIDE_W-1:0]  wide;

	always_comb begin
		is_char = 1'b1;
		digit = 4'd0;
		if (ch >= plp_pkg::CH_0 && ch <= plp_pkg::CH_9) begin
			digit = 4'(ch - plp_pkg::CH_0);
		end else if (ch >= plp_pkg::CH_LA && ch <= plp_pkg::CH_LF_HEX) begin
			digit = 4'(ch - plp_pkg::CH_LA + 8'd10);
		end else if (ch >= plp_pkg::CH_UA && ch <= plp_pkg::CH_UF) begin
			digit = 4'(ch - plp_pkg::CH_UA + 8'd10);
		end else begin
			is_char = 1'b0;
		end
	end

	always_comb begin
		case (radix)
			plp_pkg::RX_HEX: begin
				radix_ok = is_char;
				prod = {acc, 4'b0000};
			end
			plp_pkg::RX_OCT: begin
				radix_ok = is_char && (digit < 4'd8);
				prod = {1'b0, acc, 3'b000};
			end
			plp_pkg::RX_BIN: begin
				radix_ok = is_char && (digit < 4'd2);
				prod = {3'b000, acc, 1'b0};
			end
			default: begin
				radix_ok = is_char && (digit < 4'd10);
				// times ten as times eight plus times two
				prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
			end
		endcase
	end

	assign wide = prod + {{plp_pkg::ACC_W{1'b0}}, digit};
	assign acc_next = wide[plp_pkg::ACC_W-1:0];

	always_comb begin
		info.ok  = radix_ok;
		// acc * r + d above 2^63-1 means the value saturates
		info.ovf = |wide[plp_pkg::WIDE_W-1:plp_pkg::ACC_W];
	end

endmodule

// ===== rtl/plp_core.sv =====
// parse state machine: blank skip, prefix detection, digit accumulation
// depends on plp_pkg and plp_accum
module plp_core #(
	parameter int COUNT_BITS  = 16,
	parameter int RESULT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [7:0]             ch,
	input  logic                   begin_req,
	input  logic                   end_of_text,
	output plp_pkg::plp_ctl_t      ctl,
	output logic [RESULT_BITS-1:0] res_value,
	output logic [COUNT_BITS-1:0]  res_blanks,
	output logic [COUNT_BITS-1:0]  res_chars
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_BLANKS  = 3'd1;
	localparam logic [2:0] PH_ZERO    = 3'd2;
	localparam logic [2:0] PH_PREFIX  = 3'd3;
	localparam logic [2:0] PH_DPREFIX = 3'd4;
	localparam logic [2:0] PH_DIGITS  = 3'd5;

	logic [2:0]                phase_q, phase_d, phase_e;
	logic [plp_pkg::ACC_W-1:0] acc_q, acc_d, acc_e, acc_next;
	logic                      sat_q, sat_d, sat_e;
	logic [1:0]                radix_q, radix_d, radix_e;
	logic [COUNT_BITS-1:0]     blank_q, blank_d, blank_e, blank_inc;
	logic [COUNT_BITS-1:0]     char_q, char_d, char_e, char_inc;
	logic [3:0]                digit;
	plp_pkg::plp_digit_t       dinfo;
	logic                      is_blank, is_dec, dig_ok;
	logic [63:0]               full_val;

	plp_accum u_accum (
		.ch       (ch),
		.radix    (radix_e),
		.acc      (acc_e),
		.digit    (digit),
		.info     (dinfo),
		.acc_next (acc_next)
	);

	// a begin item clears the parse state and restarts in the blank-skip phase
	always_comb begin
		phase_e = begin_req ? PH_BLANKS : phase_q;
		acc_e   = begin_req ? '0 : acc_q;
		sat_e   = begin_req ? 1'b0 : sat_q;
		radix_e = begin_req ? plp_pkg::RX_DEC : radix_q;
		blank_e = begin_req ? '0 : blank_q;
		char_e  = begin_req ? '0 : char_q;
	end

	assign blank_inc = (&blank_e) ? blank_e : blank_e + 1'b1;
	assign char_inc  = (&char_e) ? char_e : char_e + 1'b1;
	assign is_blank  = (ch == plp_pkg::CH_SPACE) || (ch == plp_pkg::CH_TAB)
		|| (ch == plp_pkg::CH_CR) || (ch == plp_pkg::CH_LF);
	assign is_dec    = (ch >= plp_pkg::CH_0) && (ch <= plp_pkg::CH_9);
	assign dig_ok    = dinfo.ok && !end_of_text;
	assign full_val  = sat_e ? plp_pkg::SAT_LIMIT : {1'b0, acc_e};

	always_comb begin
		phase_d = phase_e;
		acc_d   = acc_e;
		sat_d   = sat_e;
		radix_d = radix_e;
		blank_d = blank_e;
		char_d  = char_e;
		ctl.emit    = 1'b0;
		ctl.invalid = 1'b1;
		ctl.radix   = plp_pkg::RX_DEC;
		res_value   = '0;
		res_blanks  = blank_e;
		res_chars   = '0;
		case (phase_e)
			PH_BLANKS: begin
				if (end_of_text) begin
					ctl.emit = 1'b1;
				end else if (is_blank) begin
					blank_d = blank_inc;
				end else if (ch == plp_pkg::CH_0) begin
					char_d  = COUNT_BITS'(1);
					phase_d = PH_ZERO;
				end else if (ch >= plp_pkg::CH_1 && ch <= plp_pkg::CH_9) begin
					radix_d = plp_pkg::RX_DEC;
					acc_d   = {{(plp_pkg::ACC_W-4){1'b0}}, digit};
					char_d  = COUNT_BITS'(1);
					phase_d = PH_DIGITS;
				end else begin
					ctl.emit = 1'b1;
				end
			end
			PH_ZERO: begin
				if (!end_of_text && (ch == plp_pkg::CH_X || ch == plp_pkg::CH_O
						|| ch == plp_pkg::CH_B)) begin
					radix_d = (ch == plp_pkg::CH_X) ? plp_pkg::RX_HEX :
						(ch == plp_pkg::CH_O) ? plp_pkg::RX_OCT : plp_pkg::RX_BIN;
					char_d  = COUNT_BITS'(2);
					phase_d = PH_PREFIX;
				end else if (!end_of_text && ch == plp_pkg::CH_D) begin
					radix_d = plp_pkg::RX_DEC;
					char_d  = COUNT_BITS'(2);
					phase_d = PH_DPREFIX;
				end else if (!end_of_text && is_dec) begin
					radix_d = plp_pkg::RX_DEC;
					acc_d   = {{(plp_pkg::ACC_W-4){1'b0}}, digit};
					char_d  = COUNT_BITS'(2);
					phase_d = PH_DIGITS;
				end else begin
					// lone zero
					ctl.emit    = 1'b1;
					ctl.invalid = 1'b0;
					res_chars   = COUNT_BITS'(1);
				end
			end
			PH_PREFIX, PH_DPREFIX: begin
				if (dig_ok) begin
					acc_d   = {{(plp_pkg::ACC_W-4){1'b0}}, digit};
					char_d  = COUNT_BITS'(3);
					phase_d = PH_DIGITS;
				end else if (phase_e == PH_PREFIX) begin
					// radix prefix with no digit falls back to a decimal zero
					ctl.emit    = 1'b1;
					ctl.invalid = 1'b0;
					res_chars   = COUNT_BITS'(1);
				end else begin
					ctl.emit = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (dig_ok) begin
					if (!sat_e) begin
						if (dinfo.ovf) begin
							sat_d = 1'b1;
						end else begin
							acc_d = acc_next;
						end
					end
					char_d = char_inc;
				end else begin
					ctl.emit    = 1'b1;
					ctl.invalid = 1'b0;
					ctl.radix   = radix_e;
					res_value   = full_val[RESULT_BITS-1:0];
					res_chars   = char_e;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (ctl.emit) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			radix_q <= plp_pkg::RX_DEC;
			blank_q <= '0;
			char_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			sat_q   <= sat_d;
			radix_q <= radix_d;
			blank_q <= blank_d;
			char_q  <= char_d;
		end
	end

	a_sat_holds_acc: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q && !(go && begin_req) |=> $stable(acc_q))
		else $error("accumulator moved while saturated");

	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		go && ctl.emit |=> phase_q == PH_IDLE)
		else $error("parser not idle after a result");

	a_prefix_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX || phase_q == PH_DPREFIX) |-> char_q == COUNT_BITS'(2))
		else $error("prefix phase with wrong character count");

	a_digits_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGITS |-> char_q != '0)
		else $error("digit phase with empty literal");

endmodule

// ===== bench/testbench.sv =====
// testbench for prefixed_integer_literal_parser_top: directed and random character
// streams with idle and stall phases, checked against a scoreboard with its own parser model
// depends on plp_pkg and the rtl of the parser
`timescale 1ns / 100ps

module testbench;

	localparam int VAL_W = 32;
	localparam int CNT_W = 16;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLANKS,
		PH_ZERO,
		PH_PREFIX,
		PH_DPREFIX,
		PH_DIGITS
	} parse_state_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             status;
		logic [1:0]       radix;
		logic [CNT_W-1:0] blanks;
		logic [CNT_W-1:0] chars;
	} literal_result_t;

	typedef struct packed {
		logic [7:0] c;
		logic       b;
		logic       e;
	} text_item_t;

	class literal_scoreboard;
		parse_state_t     state;
		logic [63:0]      acc;
		bit               sat;
		logic [1:0]       radix;
		logic [CNT_W-1:0] blanks;
		logic [CNT_W-1:0] chars;
		literal_result_t  expected_q[$];
		int               errors;

		function new();
			clear_parse();
			errors = 0;
		endfunction

		function void clear_parse();
			state = PH_IDLE;
			acc = '0;
			sat = 1'b0;
			radix = plp_pkg::RX_DEC;
			blanks = '0;
			chars = '0;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] n);
			return (&n) ? n : n + 1'b1;
		endfunction

		function int unsigned base_of(logic [1:0] rx);
			case (rx)
				plp_pkg::RX_HEX: return 16;
				plp_pkg::RX_OCT: return 8;
				plp_pkg::RX_BIN: return 2;
				default: return 10;
			endcase
		endfunction

		function int digit_value(logic [7:0] c, logic [1:0] rx);
			int d;
			d = -1;
			if (c >= plp_pkg::CH_0 && c <= plp_pkg::CH_9)
				d = int'(c) - int'(plp_pkg::CH_0);
			else if (c >= plp_pkg::CH_LA && c <= plp_pkg::CH_LF_HEX)
				d = int'(c) - int'(plp_pkg::CH_LA) + 10;
			else if (c >= plp_pkg::CH_UA && c <= plp_pkg::CH_UF)
				d = int'(c) - int'(plp_pkg::CH_UA) + 10;
			if (d >= int'(base_of(rx)))
				d = -1;
			return d;
		endfunction

		function void close_literal(bit ok, logic [63:0] v, logic [1:0] rx,
			logic [CNT_W-1:0] len);
			literal_result_t r;
			r.value = ok ? v[VAL_W-1:0] : '0;
			r.status = !ok;
			r.radix = ok ? rx : plp_pkg::RX_DEC;
			r.blanks = blanks;
			r.chars = ok ? len : '0;
			expected_q.push_back(r);
			state = PH_IDLE;
		endfunction

		function void note_char(logic [7:0] c, logic b, logic e);
			int d;
			if (b) begin
				clear_parse();
				state = PH_BLANKS;
			end
			case (state)
				PH_BLANKS: begin
					if (e)
						close_literal(1'b0, '0, plp_pkg::RX_DEC, '0);
					else if (c == plp_pkg::CH_SPACE || c == plp_pkg::CH_TAB
						|| c == plp_pkg::CH_CR || c == plp_pkg::CH_LF)
						blanks = bump(blanks);
					else if (c == plp_pkg::CH_0) begin
						chars = CNT_W'(1);
						state = PH_ZERO;
					end else if (c >= plp_pkg::CH_1 && c <= plp_pkg::CH_9) begin
						radix = plp_pkg::RX_DEC;
						acc = 64'(c - plp_pkg::CH_0);
						chars = CNT_W'(1);
						state = PH_DIGITS;
					end else
						close_literal(1'b0, '0, plp_pkg::RX_DEC, '0);
				end
				PH_ZERO: begin
					d = e ? -1 : digit_value(c, plp_pkg::RX_DEC);
					if (!e && (c == plp_pkg::CH_X || c == plp_pkg::CH_O
						|| c == plp_pkg::CH_B)) begin
						radix = (c == plp_pkg::CH_X) ? plp_pkg::RX_HEX :
							(c == plp_pkg::CH_O) ? plp_pkg::RX_OCT : plp_pkg::RX_BIN;
						chars = CNT_W'(2);
						state = PH_PREFIX;
					end else if (!e && c == plp_pkg::CH_D) begin
						radix = plp_pkg::RX_DEC;
						chars = CNT_W'(2);
						state = PH_DPREFIX;
					end else if (d >= 0) begin
						radix = plp_pkg::RX_DEC;
						acc = 64'(d);
						chars = CNT_W'(2);
						state = PH_DIGITS;
					end else
						close_literal(1'b1, '0, plp_pkg::RX_DEC, CNT_W'(1));
				end
				PH_PREFIX, PH_DPREFIX: begin
					// 0x/0o/0b without digit falls back to a lone zero, 0d without digit is invalid
					d = e ? -1 : digit_value(c, radix);
					if (d >= 0) begin
						acc = 64'(d);
						chars = CNT_W'(3);
						state = PH_DIGITS;
					end else
						close_literal(state == PH_PREFIX, '0, plp_pkg::RX_DEC, CNT_W'(1));
				end
				PH_DIGITS: begin
					d = e ? -1 : digit_value(c, radix);
					if (d < 0)
						close_literal(1'b1, sat ? plp_pkg::SAT_LIMIT : acc, radix, chars);
					else begin
						if (!sat) begin
							if (acc > (plp_pkg::SAT_LIMIT - 64'(d)) / 64'(base_of(radix)))
								sat = 1'b1;
							else
								acc = acc * 64'(base_of(radix)) + 64'(d);
						end
						chars = bump(chars);
					end
				end
				default: state = PH_IDLE;
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
			if (want !== seen) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_literal(logic [VAL_W-1:0] v, logic st, logic [1:0] rx,
			logic [CNT_W-1:0] nb, logic [CNT_W-1:0] nc);
			literal_result_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual value %0h status %0b",
					$time, v, st);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			compare_field("value", 64'(exp.value), 64'(v));
			compare_field("status", 64'(exp.status), 64'(st));
			compare_field("radix_code", 64'(exp.radix), 64'(rx));
			compare_field("blanks_skipped", 64'(exp.blanks), 64'(nb));
			compare_field("literal_chars", 64'(exp.chars), 64'(nc));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       ch;
	logic             begin_req;
	logic             end_of_text;
	logic             out_valid;
	logic             out_stall;
	logic [VAL_W-1:0] value;
	logic             status;
	logic [1:0]       radix_code;
	logic [CNT_W-1:0] blanks_skipped;
	logic [CNT_W-1:0] literal_chars;

	literal_scoreboard sb;
	text_item_t        text_q[$];
	int                send_idle_pct;
	int                hold_pct;
	int                literal_items;
	int                cycle_count = 0;

	logic [7:0] blank_set [4] = '{plp_pkg::CH_SPACE, plp_pkg::CH_TAB, plp_pkg::CH_CR,
		plp_pkg::CH_LF};
	logic [7:0] prefix_set [4] = '{plp_pkg::CH_X, plp_pkg::CH_O, plp_pkg::CH_B,
		plp_pkg::CH_D};
	logic [1:0] prefix_radix [4] = '{plp_pkg::RX_HEX, plp_pkg::RX_OCT, plp_pkg::RX_BIN,
		plp_pkg::RX_DEC};
	logic [7:0] term_set [6] = '{plp_pkg::CH_SPACE, ",", ";", ")", "g", plp_pkg::CH_LF};

	prefixed_integer_literal_parser_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.begin_req(begin_req),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status),
		.radix_code(radix_code),
		.blanks_skipped(blanks_skipped),
		.literal_chars(literal_chars)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < hold_pct);
	end

	// results first: an item accepted at this edge cannot produce one yet
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_literal(value, status, radix_code, blanks_skipped, literal_chars);
			if (in_valid && !in_stall)
				sb.note_char(ch, begin_req, end_of_text);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic b, input logic e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			ch = 8'($urandom_range(255));
			@(negedge clk);
		end
		in_valid = 1'b1;
		ch = c;
		begin_req = b;
		end_of_text = e;
		do @(posedge clk); while (in_stall);
	endtask

	// the first character queued for a literal carries the begin flag
	function void put_char(logic [7:0] c, logic e);
		text_item_t t;
		t.c = c;
		t.b = (text_q.size() == 0);
		t.e = e;
		text_q.push_back(t);
	endfunction

	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i].c, text_q[i].b, text_q[i].e);
		literal_items += text_q.size();
		text_q.delete();
	endtask

	task automatic run_literal(input string s, input logic [7:0] term, input logic eot);
		foreach (s[i])
			put_char(s[i], 1'b0);
		put_char(term, eot);
		send_text();
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_literal();
		int n;
		int kind;
		int k;
		int d;
		int top;
		logic [1:0] rx;
		rx = plp_pkg::RX_DEC;
		if ($urandom_range(9) < 4)
			repeat ($urandom_range(1, 3))
				put_char(blank_set[$urandom_range(3)], 1'b0);
		kind = $urandom_range(9);
		n = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
		if (kind >= 3 && kind <= 7) begin
			k = (kind == 7) ? $urandom_range(3) : kind - 3;
			put_char(plp_pkg::CH_0, 1'b0);
			put_char(prefix_set[k], 1'b0);
			rx = prefix_radix[k];
			if (kind == 7)
				n = 0;
		end else if (kind == 8) begin
			repeat ($urandom_range(1, 3))
				put_char(8'($urandom_range(255)), 1'b0);
			n = 0;
		end else if (kind == 9) begin
			if ($urandom_range(1))
				put_char(plp_pkg::CH_0, 1'b0);
			n = 0;
		end
		case (rx)
			plp_pkg::RX_HEX: top = 15;
			plp_pkg::RX_OCT: top = 7;
			plp_pkg::RX_BIN: top = 1;
			default: top = 9;
		endcase
		repeat (n) begin
			d = $urandom_range(top);
			put_char(8'(d < 10 ? int'(plp_pkg::CH_0) + d :
				int'($urandom_range(1) ? plp_pkg::CH_LA : plp_pkg::CH_UA) + d - 10), 1'b0);
		end
		// now and then no terminator, so the next begin aborts the parse
		if ($urandom_range(19) != 0) begin
			if ($urandom_range(1))
				put_char(8'($urandom_range(255)), 1'b1);
			else if ($urandom_range(2) == 0)
				put_char(8'($urandom_range(255)), 1'b0);
			else
				put_char(term_set[$urandom_range(5)], 1'b0);
		end
		send_text();
		if ($urandom_range(19) == 0)
			repeat ($urandom_range(1, 2))
				send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		begin_req = 1'b0;
		end_of_text = 1'b0;
		send_idle_pct = 0;
		hold_pct = 0;
		literal_items = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_literal("0x1F", ",", 1'b0);
		run_literal("0xab", 8'h00, 1'b1);
		run_literal("0o17", ")", 1'b0);
		run_literal("0b101", " ", 1'b0);
		put_char(plp_pkg::CH_SPACE, 1'b0);
		put_char(plp_pkg::CH_TAB, 1'b0);
		put_char(plp_pkg::CH_CR, 1'b0);
		put_char(plp_pkg::CH_LF, 1'b0);
		run_literal("42", ";", 1'b0);
		run_literal("0d99", 8'hFF, 1'b1);
		run_literal("0d", ";", 1'b0);
		run_literal("0x", "g", 1'b0);
		run_literal("0o", "8", 1'b0);
		run_literal("0b", "2", 1'b0);
		run_literal("0", ";", 1'b0);
		run_literal("0", 8'h55, 1'b1);
		run_literal("07", 8'hFF, 1'b0);
		run_literal("", ";", 1'b0);
		run_literal("", 8'hAA, 1'b1);
		run_literal("4294967295", " ", 1'b0);
		run_literal("0xFFFFFFFF", 8'hFF, 1'b0);
		run_literal("9223372036854775807", ",", 1'b0);
		run_literal("9223372036854775808", 8'h00, 1'b0);
		run_literal("0XF", ";", 1'b0);
		// characters while idle are dropped
		send_char("5", 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b1);
		// a begin in the middle of a literal restarts the parse
		send_char("1", 1'b1, 1'b0);
		send_char("2", 1'b0, 1'b0);
		run_literal("5", " ", 1'b0);
		hold_until_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  hold_pct = 0;  end
				1: begin send_idle_pct = 49; hold_pct = 0;  end
				2: begin send_idle_pct = 0;  hold_pct = 49; end
				default: begin send_idle_pct = 14; hold_pct = 14; end
			endcase
			k_target: begin
				int target;
				target = literal_items + 130;
				while (literal_items < target)
					random_literal();
			end
			hold_until_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/plp_pkg.sv
rtl/plp_accum.sv
rtl/plp_core.sv
rtl/prefixed_integer_literal_parser_top.sv
bench/testbench.sv
